// ===== sv/encoded_word_header_decoder_unit_defines.svh =====
// Assertion macros shared by the encoded-word header decoder RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef ENCODED_WORD_HEADER_DECODER_UNIT_DEFINES_SVH
`define ENCODED_WORD_HEADER_DECODER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define EWHD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define EWHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ewhd_pkg.sv =====
// Package of the encoded-word header decoder: state and bundle types, codes,
// and the per-byte decode functions. No dependencies.
package ewhd_pkg;

  // Lookahead codes
  localparam logic [2:0] LA_NONE     = 3'd0;
  localparam logic [2:0] LA_EQ_PLAIN = 3'd1;
  localparam logic [2:0] LA_QHEX1    = 3'd2;
  localparam logic [2:0] LA_QHEX2    = 3'd3;
  localparam logic [2:0] LA_ENC_SEL  = 3'd4;
  localparam logic [2:0] LA_QEND     = 3'd5;

  // Word phase codes
  localparam logic [2:0] PH_PLAIN   = 3'd0;
  localparam logic [2:0] PH_CHARSET = 3'd1;
  localparam logic [2:0] PH_SEL     = 3'd2;
  localparam logic [2:0] PH_TEXT    = 3'd3;
  localparam logic [2:0] PH_QEND    = 3'd4;

  // Characters
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_UND   = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [4:0] BITS_FULL = 5'd24;
  localparam logic [4:0] BITS_TWO  = 5'd18;
  localparam logic [4:0] BITS_ONE  = 5'd12;

  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]  phase;
    logic        q_mode;
    logic        b_mode;
    logic [2:0]  la;
    logic [7:0]  held;
    logic [23:0] acc;
    logic [4:0]  bits;
  } dec_state_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data;
    logic [2:0]              cnt;
  } emit_list_t;

  typedef struct packed {
    dec_state_t st;
    emit_list_t em;
  } dec_ctx_t;

  // One queue entry: the results of one transaction
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data;
    logic [1:0]              last_idx;
    logic                    last;
    logic                    empty;
  } bundle_t;

  // Append one byte, drop beyond the result limit
  function automatic emit_list_t emit_push(input emit_list_t e, input logic [7:0] b);
    emit_list_t r;
    r = e;
    if (r.cnt < 3'(MAX_RES)) begin
      r.data[r.cnt[1:0]] = b;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

  // Hex digit value, bit 4 set when valid (uppercase only)
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end
    if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // Base64 sextet value, bit 6 set when valid
  function automatic logic [6:0] b64_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
      return {1'b1, t[5:0]};
    end
    if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'h47;
      return {1'b1, t[5:0]};
    end
    if (c inside {[8'h30:8'h39]}) begin
      t = c + 8'h04;
      return {1'b1, t[5:0]};
    end
    if (c == 8'h2B) return {1'b1, 6'd62};
    if (c == 8'h2F) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  // Emit base64 leftovers and leave B text
  function automatic dec_ctx_t b64_leftover(input dec_ctx_t x);
    dec_ctx_t r;
    r = x;
    if (r.st.bits >= BITS_TWO) begin
      r.em = emit_push(r.em, r.st.acc[17:10]);
      r.em = emit_push(r.em, r.st.acc[9:2]);
    end else if (r.st.bits >= BITS_ONE) begin
      r.em = emit_push(r.em, r.st.acc[11:4]);
    end
    r.st.acc    = 24'd0;
    r.st.bits   = 5'd0;
    r.st.b_mode = 1'b0;
    return r;
  endfunction

  // Handle one byte with nothing pending
  function automatic dec_ctx_t take_char(input dec_ctx_t x, input logic [7:0] c);
    dec_ctx_t   r;
    logic       done;
    logic [6:0] v;
    logic [2:0] ph;
    r    = x;
    done = 1'b0;
    v    = b64_val(c);
    ph   = 3'd0;
    if (r.st.b_mode) begin
      if (c == CH_EQ) begin
        done = 1'b1;
      end else if (c == CH_QM) begin
        if (r.st.phase < PH_TEXT) begin
          r.st.phase = PH_TEXT;
          done = 1'b1;
        end else begin
          r = b64_leftover(r);
        end
      end else if (!v[6]) begin
        r = b64_leftover(r);
        done = 1'b1;
      end else begin
        r.st.acc  = {r.st.acc[17:0], v[5:0]};
        r.st.bits = r.st.bits + 5'd6;
        if (r.st.bits >= BITS_FULL) begin
          r.em = emit_push(r.em, r.st.acc[23:16]);
          r.em = emit_push(r.em, r.st.acc[15:8]);
          r.em = emit_push(r.em, r.st.acc[7:0]);
          r.st.acc  = 24'd0;
          r.st.bits = 5'd0;
        end
        done = 1'b1;
      end
    end
    if (!done) begin
      if (c == CH_EQ) begin
        if (r.st.phase == PH_PLAIN) r.st.la = LA_EQ_PLAIN;
        else if (r.st.q_mode) r.st.la = LA_QHEX1;
      end else if (c == CH_QM) begin
        if (r.st.phase == PH_PLAIN) begin
          r.em = emit_push(r.em, c);
        end else begin
          ph = r.st.phase + 3'd1;
          r.st.phase = ph;
          if (ph == PH_SEL) begin
            r.st.la = LA_ENC_SEL;
          end else if (ph >= PH_QEND) begin
            r.st.phase = PH_QEND;
            r.st.la = LA_QEND;
          end
        end
      end else if (r.st.phase == PH_CHARSET) begin
        // skip charset name
      end else if (c == CH_UND && r.st.q_mode) begin
        r.em = emit_push(r.em, CH_SPACE);
      end else begin
        r.em = emit_push(r.em, c);
      end
    end
    return r;
  endfunction

  // Resolve pending lookahead against the new byte
  function automatic dec_ctx_t resolve(input dec_ctx_t x, input logic [7:0] c);
    dec_ctx_t   r;
    logic [2:0] kind;
    logic [4:0] hc;
    logic [4:0] hh;
    r    = x;
    kind = r.st.la;
    hc   = hex_val(c);
    hh   = hex_val(r.st.held);
    r.st.la = LA_NONE;
    case (kind)
      LA_EQ_PLAIN: begin
        if (c == CH_QM) begin
          r.st.phase = PH_CHARSET;
        end else begin
          r.em = emit_push(r.em, CH_EQ);
          r = take_char(r, c);
        end
      end
      LA_QHEX1: begin
        if (hc[4]) begin
          r.st.la   = LA_QHEX2;
          r.st.held = c;
        end else begin
          r = take_char(r, c);
        end
      end
      LA_QHEX2: begin
        if (hc[4] && hh[4]) begin
          r.em = emit_push(r.em, {hh[3:0], hc[3:0]});
        end else begin
          r = take_char(r, r.st.held);
          r = take_char(r, c);
        end
        r.st.held = 8'h00;
      end
      LA_ENC_SEL: begin
        if (c == 8'h51 || c == 8'h71) begin
          r.st.q_mode = 1'b1;
        end else if (c == 8'h42 || c == 8'h62) begin
          r.st.b_mode = 1'b1;
          r.st.acc    = 24'd0;
          r.st.bits   = 5'd0;
        end else begin
          r = take_char(r, c);
        end
      end
      LA_QEND: begin
        if (c == CH_EQ) begin
          r.st.phase  = PH_PLAIN;
          r.st.q_mode = 1'b0;
        end else begin
          r.st.phase = PH_TEXT;
          r.em = emit_push(r.em, CH_QM);
          r = take_char(r, c);
        end
      end
      default: begin
        r = take_char(r, c);
      end
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ewhd_front.sv =====
// Front end: accepts header bytes, runs the decode state and packs the
// results of each transaction into one bundle. Depends on ewhd_pkg.
module ewhd_front import ewhd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_data
);

  dec_state_t st_r;
  dec_state_t st_nxt;
  dec_ctx_t   ctx;
  dec_ctx_t   res;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Decode one byte, then flush on the final byte
  always_comb begin
    ctx.st = st_r;
    ctx.em = '0;
    res = resolve(ctx, in_byte);
    if (in_end_of_text) begin
      if (res.st.la == LA_EQ_PLAIN) res.em = emit_push(res.em, CH_EQ);
      else if (res.st.la == LA_QHEX2) res.em = emit_push(res.em, res.st.held);
      else if (res.st.la == LA_QEND) res.em = emit_push(res.em, CH_QM);
      if (res.st.b_mode) res = b64_leftover(res);
      res.st = '0;
    end
    st_nxt = res.st;
  end

  // Pack the bundle; an empty final transaction carries the end marker
  always_comb begin
    push_data.data     = res.em.data;
    push_data.empty    = (res.em.cnt == 3'd0);
    push_data.last     = in_end_of_text;
    push_data.last_idx = (res.em.cnt == 3'd0) ? 2'd0 : 2'(res.em.cnt - 3'd1);
    push = accept && ((res.em.cnt != 3'd0) || in_end_of_text);
  end

  // Advance decode state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== sv/ewhd_queue.sv =====
// Bundle queue between front and back end of the header decoder.
// Depends on ewhd_pkg and the shared assertion macro header.
`include "encoded_word_header_decoder_unit_defines.svh"
module ewhd_queue import ewhd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output bundle_t head
);

  bundle_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `EWHD_ASSERT_SAME(a_count_bound, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue count overflow")
  `EWHD_ASSERT_SAME(a_no_push_full, push, !full, "push into full queue")
  `EWHD_ASSERT_SAME(a_no_pop_empty, pop, not_empty, "pop from empty queue")
  `EWHD_ASSERT_NEXT(a_push_grows, push && !pop, count_r == $past(count_r) + QCNT_W'(1),
                    "queue count did not grow on push")

endmodule

// ===== sv/ewhd_back.sv =====
// Back end: walks the head bundle one result at a time into the output
// register. Depends on ewhd_pkg.
module ewhd_back import ewhd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       not_empty,
  input  bundle_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_text
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r;
  logic       out_last_r;
  logic [1:0] sub_r;
  logic       load;
  logic       at_end;

  assign load   = not_empty && (!out_valid_r || !out_stall);
  assign at_end = (sub_r == head.last_idx);
  assign pop    = load && at_end;

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_valid   = out_bv_r;
  assign out_last_of_text = out_last_r;

  // Load the next result when the output register frees up
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head.data[sub_r];
      out_bv_r   <= !head.empty;
      out_last_r <= head.last && at_end;
    end
  end

  // Track output valid and position inside the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sub_r       <= at_end ? 2'd0 : sub_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/encoded_word_header_decoder_unit.sv =====
// Top level of the MIME encoded-word header decoder.
// Depends on ewhd_pkg, ewhd_front, ewhd_queue and ewhd_back.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_byte, in_end_of_text
//   out     | output    | out_valid/out_stall | out_byte, out_byte_valid, out_last_of_text
//
// One byte is accepted per cycle while the four-bundle queue has room.
// Each transaction yields zero to four results; the back end sends one
// result per cycle from its output register while out_stall is low, and
// the queue absorbs the burst.
// Reset (rst_n low, synchronous) clears decode state, queue and output.
// in_stall is high exactly when the queue is full.
module encoded_word_header_decoder_unit import ewhd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_text
);

  logic    push;
  bundle_t push_data;
  logic    q_full;
  logic    q_not_empty;
  logic    pop;
  bundle_t head;

  ewhd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  ewhd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  ewhd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .not_empty        (q_not_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_of_text (out_last_of_text)
  );

endmodule

// ===== sim/ewhd_decode_compare.sv =====
// Watches both channels of the encoded-word header decoder, predicts the decoded
// result stream per header byte and compares every result in order.
// Depends on ewhd_pkg for character, phase and lookahead codes.
module ewhd_decode_compare import ewhd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_last_of_text,
  output int         fail_count,
  output int         pending_results
);

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       ends_text;
  } decoded_result_t;

  decoded_result_t decoded_q[$];
  logic [7:0]      step_bytes[$];

  // Predicted decoder state
  logic [2:0]  w_phase;
  logic        in_q;
  logic        in_b;
  logic [2:0]  pending_la;
  logic [7:0]  held_byte;
  logic [23:0] sextets;
  logic [4:0]  sextet_bits;

  function automatic void clear_decoder();
    w_phase     = PH_PLAIN;
    in_q        = 1'b0;
    in_b        = 1'b0;
    pending_la  = LA_NONE;
    held_byte   = 8'h00;
    sextets     = 24'd0;
    sextet_bits = 5'd0;
  endfunction

  // Append one decoded byte, drop anything past the per-byte limit
  function automatic void put_byte(logic [7:0] b);
    if (step_bytes.size() < MAX_RES) step_bytes.push_back(b);
  endfunction

  // Uppercase hex only; -1 when not a digit
  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    return -1;
  endfunction

  // Standard base64 alphabet; -1 when invalid
  function automatic int sextet_value(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h47;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) + 4;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    return -1;
  endfunction

  // Emit base64 leftovers and leave B text
  function automatic void flush_sextets();
    if (sextet_bits >= BITS_TWO) begin
      put_byte(sextets[17:10]);
      put_byte(sextets[9:2]);
    end else if (sextet_bits >= BITS_ONE) begin
      put_byte(sextets[11:4]);
    end
    sextets     = 24'd0;
    sextet_bits = 5'd0;
    in_b        = 1'b0;
  endfunction

  // Handle one byte with nothing pending
  function automatic void plain_byte(logic [7:0] c);
    int v;
    if (in_b) begin
      if (c == CH_EQ) return;
      if (c == CH_QM) begin
        if (w_phase < PH_TEXT) begin
          w_phase = PH_TEXT;
          return;
        end
        flush_sextets();
      end else begin
        v = sextet_value(c);
        if (v < 0) begin
          flush_sextets();
          return;
        end
        sextets     = {sextets[17:0], v[5:0]};
        sextet_bits = sextet_bits + 5'd6;
        if (sextet_bits >= BITS_FULL) begin
          put_byte(sextets[23:16]);
          put_byte(sextets[15:8]);
          put_byte(sextets[7:0]);
          sextets     = 24'd0;
          sextet_bits = 5'd0;
        end
        return;
      end
    end
    if (c == CH_EQ) begin
      if (w_phase == PH_PLAIN) pending_la = LA_EQ_PLAIN;
      else if (in_q) pending_la = LA_QHEX1;
    end else if (c == CH_QM) begin
      if (w_phase == PH_PLAIN) begin
        put_byte(c);
      end else begin
        w_phase = w_phase + 3'd1;
        if (w_phase == PH_SEL) begin
          pending_la = LA_ENC_SEL;
        end else if (w_phase >= PH_QEND) begin
          w_phase    = PH_QEND;
          pending_la = LA_QEND;
        end
      end
    end else if (w_phase == PH_CHARSET) begin
      // charset name is skipped
    end else if (c == CH_UND && in_q) begin
      put_byte(CH_SPACE);
    end else begin
      put_byte(c);
    end
  endfunction

  // Settle the pending lookahead against the new byte
  function automatic void take_byte(logic [7:0] c);
    logic [2:0] kind;
    kind       = pending_la;
    pending_la = LA_NONE;
    case (kind)
      LA_EQ_PLAIN: begin
        if (c == CH_QM) begin
          w_phase = PH_CHARSET;
        end else begin
          put_byte(CH_EQ);
          plain_byte(c);
        end
      end
      LA_QHEX1: begin
        if (hex_digit(c) >= 0) begin
          pending_la = LA_QHEX2;
          held_byte  = c;
        end else begin
          plain_byte(c);
        end
      end
      LA_QHEX2: begin
        if (hex_digit(c) >= 0 && hex_digit(held_byte) >= 0) begin
          put_byte(8'(hex_digit(held_byte) * 16 + hex_digit(c)));
        end else begin
          plain_byte(held_byte);
          plain_byte(c);
        end
        held_byte = 8'h00;
      end
      LA_ENC_SEL: begin
        if (c == "Q" || c == "q") begin
          in_q = 1'b1;
        end else if (c == "B" || c == "b") begin
          in_b        = 1'b1;
          sextets     = 24'd0;
          sextet_bits = 5'd0;
        end else begin
          plain_byte(c);
        end
      end
      LA_QEND: begin
        if (c == CH_EQ) begin
          w_phase = PH_PLAIN;
          in_q    = 1'b0;
        end else begin
          w_phase = PH_TEXT;
          put_byte(CH_QM);
          plain_byte(c);
        end
      end
      default: begin
        plain_byte(c);
      end
    endcase
  endfunction

  // Predict the results of one accepted header byte
  function automatic void predict_header_byte(logic [7:0] c, logic eot);
    decoded_result_t r;
    step_bytes.delete();
    take_byte(c);
    if (eot) begin
      // flush held data at end of text
      if (pending_la == LA_EQ_PLAIN) put_byte(CH_EQ);
      else if (pending_la == LA_QHEX2) put_byte(held_byte);
      else if (pending_la == LA_QEND) put_byte(CH_QM);
      if (in_b) flush_sextets();
      clear_decoder();
    end
    foreach (step_bytes[k]) begin
      r.data      = step_bytes[k];
      r.has_data  = 1'b1;
      r.ends_text = eot && (k == step_bytes.size() - 1);
      decoded_q.push_back(r);
    end
    if (eot && step_bytes.size() == 0) begin
      r.data      = 8'h00;
      r.has_data  = 1'b0;
      r.ends_text = 1'b1;
      decoded_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Compare results first, then predict, so a result never meets its own byte
  always @(posedge clk) begin
    if (!rst_n) begin
      decoded_q.delete();
      clear_decoder();
      fail_count = 0;
      pending_results <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %02h valid %b last %b",
                   $time, out_byte, out_byte_valid, out_last_of_text);
          fail_count++;
        end else begin
          check_field("out_byte", decoded_q[0].data, out_byte);
          check_field("out_byte_valid", 8'(decoded_q[0].has_data), 8'(out_byte_valid));
          check_field("out_last_of_text", 8'(decoded_q[0].ends_text), 8'(out_last_of_text));
          void'(decoded_q.pop_front());
        end
      end
      if (in_valid && !in_stall) predict_header_byte(in_byte, in_end_of_text);
      pending_results <= decoded_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the encoded-word header decoder testbench: clock, reset, header text
// stimulus with paced handshakes, watchdog and verdict.
// Depends on ewhd_pkg, encoded_word_header_decoder_unit and ewhd_decode_compare.
module tb_top import ewhd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 150;
  localparam int PACING_PHASES  = 4;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last_of_text;
  int         fail_count;
  int         pending_results;

  int idle_pct;
  int stall_pct;
  int idle_cycles;
  int bytes_sent;
  int texts_sent;
  int results_seen;
  int random_sent;

  logic [7:0] text_bytes[$];
  string      b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string      hex_upper  = "0123456789ABCDEF";
  string      word_chars = "abcxyzQBqbAZ09 _-.,";

  encoded_word_header_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_of_text (out_last_of_text)
  );

  ewhd_decode_compare u_compare (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_of_text (out_last_of_text),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random receiver stall at the current pacing
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Count results and end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles  <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) results_seen <= results_seen + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  // Opener and charset of an encoded word up to the encoding letter
  function automatic void add_opener();
    int n;
    n = $urandom_range(0, 3);
    add_str("=?");
    repeat (n) text_bytes.push_back(pick("abcuf-8"));
    text_bytes.push_back(CH_QM);
  endfunction

  // Q word with escapes, underscores and the odd broken escape
  function automatic void add_q_word();
    int n;
    n = $urandom_range(0, 8);
    add_opener();
    text_bytes.push_back(pick("Qq"));
    text_bytes.push_back(CH_QM);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: text_bytes.push_back(pick(word_chars));
        4: text_bytes.push_back(CH_UND);
        5, 6: begin
          text_bytes.push_back(CH_EQ);
          text_bytes.push_back(pick(hex_upper));
          text_bytes.push_back(pick(hex_upper));
        end
        7: begin
          text_bytes.push_back(CH_EQ);
          text_bytes.push_back(pick("0Afg=?"));
          text_bytes.push_back(pick("9Fz_=?"));
        end
        8: begin
          text_bytes.push_back(CH_QM);
          text_bytes.push_back(pick(word_chars));
        end
        default: text_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    add_str("?=");
  endfunction

  // B word: base64 text with padding and the odd invalid character
  function automatic void add_b_word();
    int n;
    n = $urandom_range(0, 11);
    add_opener();
    text_bytes.push_back(pick("Bb"));
    text_bytes.push_back(CH_QM);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0: text_bytes.push_back(CH_EQ);
        1: text_bytes.push_back(8'($urandom_range(0, 255)));
        default: text_bytes.push_back(pick(b64_digits));
      endcase
    end
    add_str("?=");
  endfunction

  // Word with an unknown encoding letter, passes through undecoded
  function automatic void add_unknown_word();
    int n;
    n = $urandom_range(0, 5);
    add_opener();
    text_bytes.push_back(pick("XxA=_9"));
    text_bytes.push_back(CH_QM);
    repeat (n) text_bytes.push_back(pick("ab=_?Z"));
    add_str("?=");
  endfunction

  function automatic void add_plain();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) text_bytes.push_back(pick("Hi, there=?_ "));
  endfunction

  // Build one random header text, sometimes cut short inside a word
  function automatic void build_text();
    int segs;
    int keep;
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      case ($urandom_range(0, 9))
        0, 1: add_plain();
        2, 3, 4: add_q_word();
        5, 6, 7: add_b_word();
        8: add_unknown_word();
        default: text_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, text_bytes.size());
      while (text_bytes.size() > keep) void'(text_bytes.pop_back());
    end
  endfunction

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
    texts_sent++;
    text_bytes.delete();
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    out_stall      = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    bytes_sent     = 0;
    texts_sent     = 0;
    random_sent    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes and lone '=' in plain text
    text_bytes = {8'h00, CH_EQ, 8'hFF};
    send_text();
    // Q word: escape, underscore, escape broken by '?', empty charset
    add_str("=??q?=4A_=4?=");
    send_text();
    // B word: one full quad, leftover flushed at end of text
    add_str("=??B?QUJDQQ");
    send_text();
    // Text ending inside the charset gives the empty end marker
    add_str("=?");
    send_text();
    drain_results();

    // Random texts under each pacing: none, sender idle, receiver stall, both
    for (int ph = 0; ph < PACING_PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      while (random_sent < (ph + 1) * RANDOM_BYTES / PACING_PHASES) begin
        build_text();
        random_sent += text_bytes.size();
        send_text();
      end
      drain_results();
    end

    // Let the pipeline settle after the last result
    repeat (20) @(posedge clk);
    $display("Sent %0d header bytes in %0d texts (plain, Q, B, unknown and cut-off words)",
             bytes_sent, texts_sent);
    $display("Checked %0d decoded results under four handshake pacing mixes", results_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
